>>> hdl/gtc_pkg.sv
// Shared types, widths and constants for the geographic to Cartesian converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package gtc_pkg;

    // Stream field widths
    localparam int LON_W       = 25;
    localparam int LAT_W       = 24;
    localparam int RADIUS_W    = 32;
    localparam int COORD_W     = 33;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 104;

    // Internal angle is degrees with 24 fraction bits
    localparam int ANGLE_FRAC = 24;
    localparam int ANGLE_W    = 32;
    // CORDIC datapath, sin/cos in Q2.30
    localparam int ROT_W      = 33;
    localparam int TRIG_W     = 32;
    localparam int TRIG_FRAC  = 30;

    localparam int CORDIC_ITERATIONS_DEF = 24;
    localparam int FRACTION_BITS_DEF     = 16;
    localparam int QUEUE_DEPTH           = 4;

    localparam int LANES    = 2;
    localparam int LANE_LON = 0;
    localparam int LANE_LAT = 1;

    // Reciprocal of the converged CORDIC gain in Q2.30
    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [31:0] ATAN_DEG_Q24 [32] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115,
        32'd57,        32'd29,        32'd14,        32'd7,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    // One angle after range folding: within +-90 degrees, plus a flag that
    // negates both sine and cosine.
    typedef struct packed {
        logic                      neg;
        logic signed [ANGLE_W-1:0] angle;
    } lane_t;

    typedef struct packed {
        lane_t                lon;
        lane_t                lat;
        logic [RADIUS_W-1:0]  radius;
    } item_t;

    // Number of conditional subtract steps needed to bring any 25-bit input
    // angle into one turn, for a given number of input fraction bits.
    function automatic int wrap_steps(input int frac);
        int s;
        s = 0;
        for (int k = 0; k < 32; k++) begin
            if ((longint'(360) << (frac + s)) < (longint'(1) << 24)) begin
                s = s + 1;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> hdl/gtc_front.sv
// Front end: takes input transactions, reduces both angles to one turn and
// folds them into +-90 degrees. Depends on gtc_pkg.
`default_nettype none

module gtc_front
    import gtc_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // longitude_deg[24:0], latitude_deg[48:25], radius[80:49], zero pad
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output item_t                      push_item
);

    localparam int RED_W     = (FRACTION_BITS + 11 > 27) ? FRACTION_BITS + 11 : 27;
    localparam int RED_STEPS = wrap_steps(FRACTION_BITS);
    localparam int ANG_SHIFT = ANGLE_FRAC - FRACTION_BITS;

    localparam logic signed [RED_W-1:0] MOD_DEG     = RED_W'(longint'(360) << FRACTION_BITS);
    localparam logic signed [RED_W-1:0] HALF_DEG    = RED_W'(longint'(180) << FRACTION_BITS);
    localparam logic signed [RED_W-1:0] QUARTER_DEG = RED_W'(longint'(90) << FRACTION_BITS);
    // multiple of one turn that is at least 2^24, lifts any negative input
    localparam logic signed [RED_W-1:0] LIFT_DEG    =
        RED_W'(longint'(360) << (FRACTION_BITS + RED_STEPS));

    function automatic lane_t fold_angle(input logic signed [RED_W-1:0] a);
        logic signed [RED_W-1:0]   v;
        logic signed [ANGLE_W-1:0] t;
        lane_t                     res;
        v = a;
        if (a < 0) begin
            v = a + LIFT_DEG;
        end
        // v is now in [0, 360 << (frac + steps)); restoring reduction
        for (int j = RED_STEPS - 1; j >= 0; j--) begin
            if (v >= (MOD_DEG <<< j)) begin
                v = v - (MOD_DEG <<< j);
            end
        end
        if (v >= HALF_DEG) begin
            v = v - MOD_DEG;
        end
        res.neg = 1'b0;
        if (v > QUARTER_DEG) begin
            v       = v - HALF_DEG;
            res.neg = 1'b1;
        end
        else if (v < -QUARTER_DEG) begin
            v       = v + HALF_DEG;
            res.neg = 1'b1;
        end
        t         = ANGLE_W'(v);
        res.angle = t <<< ANG_SHIFT;
        return res;
    endfunction

    logic signed [RED_W-1:0] lon_in;
    logic signed [RED_W-1:0] lat_in;

    assign lon_in = RED_W'($signed(s_tdata[LON_W-1:0]));
    assign lat_in = RED_W'($signed(s_tdata[LON_W+LAT_W-1:LON_W]));

    assign push_valid       = s_tvalid;
    assign s_tready         = push_ready;
    assign push_item.lon    = fold_angle(lon_in);
    assign push_item.lat    = fold_angle(lat_in);
    assign push_item.radius = s_tdata[LON_W+LAT_W+RADIUS_W-1:LON_W+LAT_W];

endmodule

`default_nettype wire

>>> hdl/gtc_queue.sv
// Short FIFO between the front end and the CORDIC back end.
// Depends on gtc_pkg for the queued item type.
`default_nettype none

module gtc_queue
    import gtc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_item,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output item_t      pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gtc_back.sv
// Back end: two-lane unrolled CORDIC pipeline (longitude, latitude), sign fix
// and clamp, then two multiply stages into the output register. Uses gtc_pkg.
`default_nettype none

module gtc_back
    import gtc_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    output logic                        q_ready,
    input  wire item_t                  q_item,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // x_coord[32:0], y_coord[65:33], z_coord[98:66], zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int N     = CORDIC_ITERATIONS;
    localparam int DEPTH = N + 4;   // load, N rotations, fix, two multiplies
    localparam int PAD_W = OUT_TDATA_W - 3 * COORD_W;

    localparam logic signed [ROT_W-1:0]      TRIG_ONE   = ROT_W'(64'd1 << TRIG_FRAC);
    localparam logic signed [2*TRIG_W-1:0]   ROUND_P    = (2*TRIG_W)'(64'd1 << (TRIG_FRAC - 1));
    localparam logic signed [COORD_W+TRIG_W-1:0] ROUND_R =
        (COORD_W+TRIG_W)'(64'd1 << (TRIG_FRAC - 1));

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } rot_t;

    function automatic logic signed [TRIG_W-1:0] fix_trig(
        input logic signed [ROT_W-1:0] v,
        input logic                    neg
    );
        logic signed [ROT_W-1:0] w;
        w = neg ? -v : v;
        if (w > TRIG_ONE) begin
            w = TRIG_ONE;
        end
        else if (w < -TRIG_ONE) begin
            w = -TRIG_ONE;
        end
        return TRIG_W'(w);
    endfunction

    logic                en;
    logic [DEPTH-1:0]    valid_reg;

    rot_t                rot_reg  [N+1][LANES];
    rot_t                rot_next [N+1][LANES];
    logic                neg_reg  [N+1][LANES];
    logic [RADIUS_W-1:0] rad_reg  [N+1];

    logic signed [TRIG_W-1:0] clon_reg, slon_reg, clat_reg, slat_reg;
    logic [RADIUS_W-1:0]      rad_fix_reg;

    logic signed [2*TRIG_W-1:0] prod_c, prod_s;
    logic signed [TRIG_W-1:0]   pc_next, ps_next;
    logic signed [TRIG_W-1:0]   pc_reg, ps_reg, slat_mul_reg;
    logic [RADIUS_W-1:0]        rad_mul_reg;

    logic signed [COORD_W-1:0]         rad_s;
    logic signed [COORD_W+TRIG_W-1:0]  prod_x, prod_y, prod_z;
    logic signed [COORD_W-1:0]         x_next, y_next, z_next;
    logic signed [COORD_W-1:0]         x_reg, y_reg, z_reg;

    // whole pipeline advances together unless the output holds a stalled result
    assign en       = !valid_reg[DEPTH-1] || m_tready;
    assign q_ready  = en;
    assign m_tvalid = valid_reg[DEPTH-1];
    assign m_tdata  = {{PAD_W{1'b0}}, z_reg, y_reg, x_reg};

    // one micro-rotation per stage, both lanes side by side
    always_comb begin
        logic signed [ROT_W-1:0] dx;
        logic signed [ROT_W-1:0] dy;
        logic signed [ROT_W-1:0] at;
        for (int l = 0; l < LANES; l++) begin
            rot_next[0][l] = rot_reg[0][l];
        end
        for (int k = 0; k < N; k++) begin
            for (int l = 0; l < LANES; l++) begin
                dx = rot_reg[k][l].y >>> k;
                dy = rot_reg[k][l].x >>> k;
                at = ROT_W'(ATAN_DEG_Q24[5'(k)]);
                if (!rot_reg[k][l].z[ROT_W-1]) begin
                    rot_next[k+1][l].x = rot_reg[k][l].x - dx;
                    rot_next[k+1][l].y = rot_reg[k][l].y + dy;
                    rot_next[k+1][l].z = rot_reg[k][l].z - at;
                end
                else begin
                    rot_next[k+1][l].x = rot_reg[k][l].x + dx;
                    rot_next[k+1][l].y = rot_reg[k][l].y - dy;
                    rot_next[k+1][l].z = rot_reg[k][l].z + at;
                end
            end
        end
    end

    assign prod_c  = clat_reg * clon_reg;
    assign prod_s  = clat_reg * slon_reg;
    assign pc_next = TRIG_W'((prod_c + ROUND_P) >>> TRIG_FRAC);
    assign ps_next = TRIG_W'((prod_s + ROUND_P) >>> TRIG_FRAC);

    assign rad_s  = $signed({1'b0, rad_mul_reg});
    assign prod_x = rad_s * pc_reg;
    assign prod_y = rad_s * ps_reg;
    assign prod_z = rad_s * slat_mul_reg;
    assign x_next = COORD_W'((prod_x + ROUND_R) >>> TRIG_FRAC);
    assign y_next = COORD_W'((prod_y + ROUND_R) >>> TRIG_FRAC);
    assign z_next = COORD_W'((prod_z + ROUND_R) >>> TRIG_FRAC);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], q_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rot_reg[0][LANE_LON] <= '{x: CORDIC_GAIN, y: '0, z: ROT_W'(q_item.lon.angle)};
            rot_reg[0][LANE_LAT] <= '{x: CORDIC_GAIN, y: '0, z: ROT_W'(q_item.lat.angle)};
            neg_reg[0][LANE_LON] <= q_item.lon.neg;
            neg_reg[0][LANE_LAT] <= q_item.lat.neg;
            rad_reg[0]           <= q_item.radius;
            for (int k = 1; k <= N; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    rot_reg[k][l] <= rot_next[k][l];
                    neg_reg[k][l] <= neg_reg[k-1][l];
                end
                rad_reg[k] <= rad_reg[k-1];
            end

            clon_reg    <= fix_trig(rot_reg[N][LANE_LON].x, neg_reg[N][LANE_LON]);
            slon_reg    <= fix_trig(rot_reg[N][LANE_LON].y, neg_reg[N][LANE_LON]);
            clat_reg    <= fix_trig(rot_reg[N][LANE_LAT].x, neg_reg[N][LANE_LAT]);
            slat_reg    <= fix_trig(rot_reg[N][LANE_LAT].y, neg_reg[N][LANE_LAT]);
            rad_fix_reg <= rad_reg[N];

            pc_reg       <= pc_next;
            ps_reg       <= ps_next;
            slat_mul_reg <= slat_reg;
            rad_mul_reg  <= rad_fix_reg;

            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/geographic_to_cartesian.sv
// Top level of the geographic to Cartesian converter: front end, queue, back end.
// Depends on gtc_pkg, gtc_front, gtc_queue and gtc_back.
//
// Channel  Dir  Signals                    Contents
// s_*      in   s_tvalid/s_tready/s_tdata  longitude_deg, latitude_deg, radius
// m_*      out  m_tvalid/m_tready/m_tdata  x_coord, y_coord, z_coord
//
// One transaction in and one out per cycle when the output is not stalled.
// After its input is taken, a transaction passes the queue, a load register, the
// unrolled CORDIC, a sign/clamp stage and two multiply stages before its result
// is valid.
// A stall on m_tready freezes the back end; the four-entry queue keeps taking
// input until it fills. Reset clears only queue pointers, queue count and valid bits.
`default_nettype none

module geographic_to_cartesian
    import gtc_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
    parameter int FRACTION_BITS     = FRACTION_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // longitude_deg[24:0], latitude_deg[48:25], radius[80:49], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // x_coord[32:0], y_coord[65:33], z_coord[98:66], zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    gtc_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    gtc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    gtc_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> hdl/gtc_checker.sv
// Port-level checks for geographic_to_cartesian, attached by bind.
// Depends on gtc_pkg.
`default_nettype none

module gtc_checker
    import gtc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [IN_TDATA_W-1:0]  s_tdata,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // waiting input transaction must stay
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input transaction changed while waiting");

    // stalled result must stay
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // reset empties the pipeline and the queue
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid && s_tready)
        else $error("block not empty during reset");

    // unused top bits of a result are zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:3*COORD_W] == '0)
        else $error("nonzero pad bits in result transaction");

endmodule

bind geographic_to_cartesian gtc_checker u_gtc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/tb_geographic_to_cartesian.sv
// Self-checking bench for geographic_to_cartesian: a directed table, then random points
// under three idle patterns, each checked against its typed x, y, z or an in-bench CORDIC model.
// Depends on gtc_pkg (stream widths) and the RTL top level only.
`default_nettype none

module tb_geographic_to_cartesian;
    import gtc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     N_ROT       = 24;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint ROUND_HALF  = 64'sd536870912;
    localparam longint TURN_Q24    = 64'sd6039797760;
    localparam longint HALF_Q24    = 64'sd3019898880;
    localparam longint QUARTER_Q24 = 64'sd1509949440;
    localparam int     DEG90       = 5898240;
    localparam int     DEG180      = 11796480;
    localparam int     LONG_STALL  = 300;
    localparam int     TAIL_CYCLES = 60;
    localparam int     N_RANDOM    = 1230;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } xyz_t;

    typedef struct packed {
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
        logic [RADIUS_W-1:0]     radius;
        logic                    typed;
        xyz_t                    xyz;
    } point_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // expectation typed into the table travels with the transaction
    logic                   drv_typed = 1'b0;
    xyz_t                   drv_typed_xyz = '0;

    xyz_t   pending_xyz [$];
    int     n_errors = 0;
    int     n_points = 0;
    int     n_results = 0;
    int     src_idle_pct = 0;
    int     dst_idle_pct = 0;
    bit     stall_req = 1'b0;

    longint atan_q24 [0:N_ROT-1] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    // lon, lat, radius, typed, {x, y, z}
    point_row_t point_table [23] = '{
        '{25'sd0, 24'sd0, 32'h0, 1'b1, '0},
        '{25'sd16777215, 24'sd8388607, 32'h0, 1'b1, '0},
        '{-25'sd16777216, -24'sd8388608, 32'h0, 1'b1, '0},
        '{25'sd0, 24'sd0, 32'hFFFF_FFFF, 1'b0, '0},
        '{25'sd0, 24'sd5898240, 32'hFFFF_FFFF, 1'b0, '0},
        '{25'sd0, -24'sd5898240, 32'hFFFF_FFFF, 1'b0, '0},
        '{25'sd5898240, 24'sd0, 32'h0001_0000, 1'b0, '0},
        '{-25'sd5898240, 24'sd0, 32'h0001_0000, 1'b0, '0},
        '{25'sd11796480, 24'sd0, 32'h0001_0000, 1'b0, '0},
        '{-25'sd11796480, 24'sd0, 32'h0001_0000, 1'b0, '0},
        '{-25'sd16777216, -24'sd8388608, 32'hFFFF_FFFF, 1'b0, '0},
        '{25'sd16777215, 24'sd8388607, 32'hFFFF_FFFF, 1'b0, '0},
        '{25'sd6553600, 24'sd6553600, 32'h000A_0000, 1'b0, '0},
        '{-25'sd6553600, -24'sd6553600, 32'h0001_0000, 1'b0, '0},
        '{25'sd16384000, 24'sd1966080, 32'h0064_0000, 1'b0, '0},
        '{25'sd2949120, 24'sd2949120, 32'h0000_0001, 1'b0, '0},
        '{-25'sd2949120, 24'sd1966080, 32'h8000_0000, 1'b0, '0},
        '{25'sd1, -24'sd1, 32'hFFFF_FFFF, 1'b0, '0},
        '{25'sd5898241, 24'sd5898239, 32'h1234_5678, 1'b0, '0},
        '{-25'sd11796481, 24'sd0, 32'hFFFF_FFFF, 1'b0, '0},
        '{25'sd11796479, -24'sd5898241, 32'hFFFF_FFFF, 1'b0, '0},
        '{25'sd0, 24'sd0, 32'h0001_0000, 1'b0, '0},
        '{-25'sd1, 24'sd1, 32'h7FFF_FFFF, 1'b0, '0}
    };

    geographic_to_cartesian i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // angle in degrees with 16 fraction bits; sine and cosine in Q2.30
    function automatic void cordic_deg_sincos(input longint angle,
                                              output longint sin_q30,
                                              output longint cos_q30);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = angle * 256;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        z = z % TURN_Q24;
        if (z < -HALF_Q24)
            z = z + TURN_Q24;
        if (z >= HALF_Q24)
            z = z - TURN_Q24;
        // fold into +-90 degrees; the half turn flips both signs
        if (z > QUARTER_Q24)
        begin
            z = z - HALF_Q24;
            flip = 1'b1;
        end
        else if (z < -QUARTER_Q24)
        begin
            z = z + HALF_Q24;
            flip = 1'b1;
        end
        for (int i = 0; i < N_ROT; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q24[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q24[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_q30 = (x > ONE_Q30) ? ONE_Q30 : (x < -ONE_Q30) ? -ONE_Q30 : x;
        sin_q30 = (y > ONE_Q30) ? ONE_Q30 : (y < -ONE_Q30) ? -ONE_Q30 : y;
    endfunction

    function automatic longint round_q30(input longint p);
        return (p + ROUND_HALF) >>> 30;
    endfunction

    function automatic xyz_t geo_to_xyz(input logic signed [LON_W-1:0] lon,
                                        input logic signed [LAT_W-1:0] lat,
                                        input logic [RADIUS_W-1:0] radius);
        longint slon;
        longint clon;
        longint slat;
        longint clat;
        longint r;
        xyz_t   res;
        r = longint'(radius);
        cordic_deg_sincos(longint'(lon), slon, clon);
        cordic_deg_sincos(longint'(lat), slat, clat);
        res.x = COORD_W'(round_q30(r * round_q30(clat * clon)));
        res.y = COORD_W'(round_q30(r * round_q30(clat * slon)));
        res.z = COORD_W'(round_q30(r * slat));
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < 30)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        n_errors++;
    endtask

    // input transactions become expectations; output transactions are checked in order
    always @(posedge clk)
    begin
        xyz_t got;
        xyz_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (drv_typed)
                    pending_xyz.push_back(drv_typed_xyz);
                else
                    pending_xyz.push_back(geo_to_xyz(s_tdata[24:0], s_tdata[48:25],
                                                     s_tdata[80:49]));
            end
            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[32:0];
                got.y = m_tdata[65:33];
                got.z = m_tdata[98:66];
                n_results++;
                if (pending_xyz.size() == 0)
                    report_mismatch($sformatf("result with nothing pending: x=%0d y=%0d z=%0d",
                                              got.x, got.y, got.z));
                else
                begin
                    want = pending_xyz.pop_front();
                    if (got.x !== want.x)
                        report_mismatch($sformatf("result %0d x_coord got %0d want %0d",
                                                  n_results, got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("result %0d y_coord got %0d want %0d",
                                                  n_results, got.y, want.y));
                    if (got.z !== want.z)
                        report_mismatch($sformatf("result %0d z_coord got %0d want %0d",
                                                  n_results, got.z, want.z));
                end
            end
        end
    end

    // output side: random backpressure, or a long hold-off on request
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_req = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    task automatic send_point(input logic signed [LON_W-1:0] lon,
                              input logic signed [LAT_W-1:0] lat,
                              input logic [RADIUS_W-1:0] radius,
                              input logic typed, input xyz_t typed_xyz);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= {7'b0, radius, lat, lon};
        drv_typed     <= typed;
        drv_typed_xyz <= typed_xyz;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_points++;
    endtask

    task automatic send_random_point();
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
        logic [RADIUS_W-1:0]     radius;
        int                      pick;
        // mostly legal angles, some anywhere in the field
        if ($urandom_range(99) < 15)
        begin
            lon = LON_W'($urandom);
            lat = LAT_W'($urandom);
        end
        else
        begin
            lon = LON_W'(int'($urandom_range(2 * DEG180)) - DEG180);
            lat = LAT_W'(int'($urandom_range(2 * DEG90)) - DEG90);
        end
        pick = $urandom_range(99);
        if (pick < 40)
            radius = $urandom;
        else if (pick < 70)
            radius = $urandom_range(32'h0010_0000);
        else if (pick < 80)
            radius = 32'hFFFF_FFFF;
        else if (pick < 90)
            radius = 32'h0;
        else
            radius = 32'h1 << $urandom_range(31);
        send_point(lon, lat, radius, 1'b0, '0);
    endtask

    task automatic drain_results();
        while (pending_xyz.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        // falling edge at time zero so the asynchronous reset takes effect at once
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 27;
        dst_idle_pct = 61;
        foreach (point_table[i])
            send_point(point_table[i].lon, point_table[i].lat, point_table[i].radius,
                       point_table[i].typed, point_table[i].xyz);
        repeat (N_RANDOM / 3)
            send_random_point();

        // sender pauses until every result is back
        s_tvalid <= 1'b0;
        drain_results();
        @(posedge clk);

        src_idle_pct = 61;
        dst_idle_pct = 27;
        repeat (N_RANDOM / 3)
            send_random_point();

        // no idling; a long output hold-off lets the block fill and stall its input
        src_idle_pct = 0;
        dst_idle_pct = 0;
        stall_req = 1'b1;
        repeat (N_RANDOM - 2 * (N_RANDOM / 3))
            send_random_point();
        s_tvalid <= 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d points (%0d table rows, rest random) and %0d results,",
                 n_points, $size(point_table), n_results);
        $display("with swapped idle patterns and a %0d-cycle output hold-off.", LONG_STALL);
        if (pending_xyz.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_xyz.size()));
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_xyz.size());
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> geographic_to_cartesian.f
hdl/gtc_pkg.sv
hdl/gtc_front.sv
hdl/gtc_queue.sv
hdl/gtc_back.sv
hdl/geographic_to_cartesian.sv
hdl/gtc_checker.sv
bench/tb_geographic_to_cartesian.sv
